/* hw/rtl/h4d_pkg.sv */
// ----------------------------------------------------------------------------
// H4 deframer package
// Shared types and codes for the HCI UART H4 deframer.
// ----------------------------------------------------------------------------
package h4d_pkg;

  localparam logic [15:0] MaxAclReset = 16'd1020;

  // packet indicator bytes
  localparam logic [7:0] IndAcl = 8'h02;
  localparam logic [7:0] IndSco = 8'h03;
  localparam logic [7:0] IndEvt = 8'h04;

  // packet_kind codes
  localparam logic [1:0] KindAcl  = 2'd0;
  localparam logic [1:0] KindSco  = 2'd1;
  localparam logic [1:0] KindEvt  = 2'd2;
  localparam logic [1:0] KindNone = 2'd3;

  // byte_role codes
  localparam logic [1:0] RoleInd     = 2'd0;
  localparam logic [1:0] RoleHdr     = 2'd1;
  localparam logic [1:0] RolePayload = 2'd2;
  localparam logic [1:0] RoleDrop    = 2'd3;

  // fault codes
  localparam logic [1:0] FltNone    = 2'd0;
  localparam logic [1:0] FltBadInd  = 2'd1;
  localparam logic [1:0] FltAclLen  = 2'd2;
  localparam logic [1:0] FltLineErr = 2'd3;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       line_error;
  } item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] packet_kind;
    logic [1:0] byte_role;
    logic       start_of_packet;
    logic       end_of_packet;
    logic [1:0] fault;
    logic       halted;
  } result_t;

endpackage

/* hw/rtl/h4d_in_reg.sv */
// ----------------------------------------------------------------------------
// H4 deframer input register
// Holds one received beat until the parser consumes it.
// ----------------------------------------------------------------------------
module h4d_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  h4d_pkg::item_t in_item_i,
  input  logic           take_i,     // parser consumes the held beat
  output logic           valid_o,
  output h4d_pkg::item_t item_o
);
  import h4d_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* hw/rtl/h4d_parser.sv */
// ----------------------------------------------------------------------------
// H4 deframer parser
// Framing state machine: tags one byte per fire and updates packet state.
// ----------------------------------------------------------------------------
module h4d_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_data_i,
  input  logic             fire_i,
  input  h4d_pkg::item_t   item_i,
  output h4d_pkg::result_t result_o
);
  import h4d_pkg::*;

  localparam logic [1:0] PhInd     = 2'd0;
  localparam logic [1:0] PhHdr     = 2'd1;
  localparam logic [1:0] PhPayload = 2'd2;

  logic [15:0] max_acl_q;
  logic [1:0]  phase_q, phase_d;
  logic [1:0]  kind_q, kind_d;
  logic [2:0]  hidx_q, hidx_d;
  logic [7:0]  len_lo_q, len_lo_d;
  logic [15:0] left_q, left_d;
  logic        halt_q, halt_d;

  logic [2:0]  hlen;
  logic        last_hdr;
  logic [15:0] len;
  logic [7:0]  b;
  result_t     res;

  assign b    = item_i.rx_byte;
  assign hlen = (kind_q == KindAcl) ? 3'd4 : (kind_q == KindSco) ? 3'd3 : 3'd2;
  assign last_hdr = ({1'b0, hidx_q} + 4'd1) >= {1'b0, hlen};
  assign len  = (kind_q == KindAcl) ? {b, len_lo_q} : {8'd0, b};

  always_comb begin
    phase_d  = phase_q;
    kind_d   = kind_q;
    hidx_d   = hidx_q;
    len_lo_d = len_lo_q;
    left_d   = left_q;
    halt_d   = halt_q;

    res.data_byte       = b;
    res.packet_kind     = kind_q;
    res.byte_role       = RoleHdr;
    res.start_of_packet = 1'b0;
    res.end_of_packet   = 1'b0;
    res.fault           = FltNone;

    if (halt_q) begin
      res.packet_kind = KindNone;
      res.byte_role   = RoleDrop;
    end else if (item_i.line_error) begin
      halt_d          = 1'b1;
      res.packet_kind = KindNone;
      res.byte_role   = RoleDrop;
      res.fault       = FltLineErr;
    end else begin
      unique case (phase_q)
        PhHdr: begin
          if (kind_q == KindAcl && hidx_q == 3'd2) begin
            len_lo_d = b;
          end
          if (!last_hdr) begin
            hidx_d = hidx_q + 3'd1;
          end else if (kind_q == KindAcl && len > max_acl_q) begin
            halt_d    = 1'b1;
            res.fault = FltAclLen;
          end else begin
            hidx_d = 3'd0;
            if (len == 16'd0) begin
              phase_d           = PhInd;
              res.end_of_packet = 1'b1;
            end else begin
              left_d  = len;
              phase_d = PhPayload;
            end
          end
        end
        PhPayload: begin
          res.byte_role = RolePayload;
          if (left_q <= 16'd1) begin
            left_d            = 16'd0;
            phase_d           = PhInd;
            res.end_of_packet = 1'b1;
          end else begin
            left_d = left_q - 16'd1;
          end
        end
        default: begin
          // indicator phase, unused phase code lands here too
          phase_d       = PhInd;
          hidx_d        = 3'd0;
          res.byte_role = RoleInd;
          if (b == IndAcl || b == IndSco || b == IndEvt) begin
            kind_d              = 2'(b - IndAcl);
            phase_d             = PhHdr;
            res.packet_kind     = 2'(b - IndAcl);
            res.start_of_packet = 1'b1;
          end else begin
            halt_d          = 1'b1;
            res.packet_kind = KindNone;
            res.fault       = FltBadInd;
          end
        end
      endcase
    end

    res.halted = halt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_acl_q <= MaxAclReset;
      phase_q   <= PhInd;
      kind_q    <= KindAcl;
      hidx_q    <= 3'd0;
      len_lo_q  <= 8'd0;
      left_q    <= 16'd0;
      halt_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_acl_q <= cfg_data_i;
      end
      if (fire_i) begin
        phase_q  <= phase_d;
        kind_q   <= kind_d;
        hidx_q   <= hidx_d;
        len_lo_q <= len_lo_d;
        left_q   <= left_d;
        halt_q   <= halt_d;
      end
    end
  end

  assign result_o = res;

endmodule

/* hw/rtl/h4d_out_reg.sv */
// ----------------------------------------------------------------------------
// H4 deframer result register
// Holds one tagged beat until downstream takes it.
// ----------------------------------------------------------------------------
module h4d_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  h4d_pkg::result_t result_i,
  output logic             ready_o,    // register can take a beat this cycle
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output h4d_pkg::result_t result_o
);
  import h4d_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = load_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule

/* hw/rtl/hci_uart_h4_deframer.sv */
// ----------------------------------------------------------------------------
// HCI UART H4 deframer
// Tags each received H4 byte as indicator, header, payload or dropped byte.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir | handshake
//  --------+-------------------------------------------+-----+------------------
//  in      | rx_byte_i, line_error_i                   | in  | in_valid_i/in_stall_o
//  out     | data_byte_o, packet_kind_o, byte_role_o,  | out | out_valid_o/out_stall_i
//          | start_of_packet_o, end_of_packet_o,       |     |
//          | fault_o, halted_o                         |     |
//  cfg     | max_acl_payload_i                         | in  | cfg_valid_i/cfg_ready_o
//
// One beat per cycle sustained while out_stall_i is low. A beat is held in the input
// register, passes through the parser and is registered in the result register.
// Reset puts the parser in the indicator phase with the ACL limit at 1020. Output
// stall backs up into the input register, and in_stall_o rises only when both
// registers hold beats. Config writes are always ready.
// ----------------------------------------------------------------------------
module hci_uart_h4_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        line_error_i,
  // result beats
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  data_byte_o,
  output logic [1:0]  packet_kind_o,
  output logic [1:0]  byte_role_o,
  output logic        start_of_packet_o,
  output logic        end_of_packet_o,
  output logic [1:0]  fault_o,
  output logic        halted_o,
  // config write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] max_acl_payload_i
);
  import h4d_pkg::*;

  item_t   in_item, held_item;
  logic    held_valid;
  logic    out_ready;
  logic    fire;        // held beat moves through the parser into the result reg
  result_t parsed, res;

  assign in_item.rx_byte    = rx_byte_i;
  assign in_item.line_error = line_error_i;

  assign fire        = held_valid && out_ready;
  assign cfg_ready_o = 1'b1;

  h4d_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .take_i     (fire),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  h4d_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (max_acl_payload_i),
    .fire_i     (fire),
    .item_i     (held_item),
    .result_o   (parsed)
  );

  h4d_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .result_i    (parsed),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (res)
  );

  assign data_byte_o       = res.data_byte;
  assign packet_kind_o     = res.packet_kind;
  assign byte_role_o       = res.byte_role;
  assign start_of_packet_o = res.start_of_packet;
  assign end_of_packet_o   = res.end_of_packet;
  assign fault_o           = res.fault;
  assign halted_o          = res.halted;

endmodule
